FILE: src/adcppf_pkg.sv
// Shared types, register indexes and constants of the ADC pulse peak finder.
package adcppf_pkg;

    localparam int SAMPLE_W   = 13;
    localparam int BUCKET_W   = 10;
    localparam int OUT_BKT_W  = 9;
    localparam int ORD_W      = 9;
    localparam int LEN_W      = 3;
    localparam int CFG_W      = 12;
    localparam int CFG_ADDR_W = 3;
    localparam int TAPS       = 10;
    localparam int CMP_W      = 15;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    // Largest bucket count honored per pad
    localparam logic [BUCKET_W-1:0] MAX_BUCKETS = 10'd512;
    localparam logic [BUCKET_W-1:0] BUCKET_MAX  = 10'd1023;
    localparam logic [ORD_W-1:0]    ORD_MAX     = 9'd511;
    localparam logic [BUCKET_W:0]   END_MARGIN  = 11'd5;
    localparam logic signed [CMP_W-1:0] TOL_NEG = -15'sd10;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_HEIGHT_THR = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SAT_LEVEL  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FIRST_BKT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SAMPLES    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_RISE   = 3'd4;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [TAPS-1:0][SAMPLE_W-1:0] t_taps;

    typedef struct packed {
        logic [CFG_W-1:0]    height_threshold;
        logic [CFG_W-1:0]    saturation_level;
        logic [8:0]          first_active_bucket;
        logic [BUCKET_W-1:0] samples_per_pad;
        logic [CFG_W-1:0]    minimum_rise;
    } t_cfg;

    typedef struct packed {
        logic                 hit;
        logic [LEN_W-1:0]     plateau_length;
        logic [OUT_BKT_W-1:0] peak_bucket;
        logic [SAMPLE_W-1:0]  peak_height;
    } t_cls;

    // Sign-extend a sample to the comparison width
    function automatic logic signed [CMP_W-1:0] sx(input logic [SAMPLE_W-1:0] v);
        sx = $signed({{(CMP_W-SAMPLE_W){v[SAMPLE_W-1]}}, v});
    endfunction

    // Zero-extend a register value to the comparison width
    function automatic logic signed [CMP_W-1:0] zx(input logic [CFG_W-1:0] v);
        zx = $signed({{(CMP_W-CFG_W){1'b0}}, v});
    endfunction

endpackage

FILE: src/adc_pulse_peak_finder_top.sv
// ADC pulse peak finder: input stream of samples, output stream of peaks.
//
// Slave stream carries one pedestal-subtracted sample per time bucket;
// s_axis_tuser marks the first sample of a pad, which clears the window,
// the bucket counter and the peak ordinal. Master stream carries one record
// per detected peak or saturated plateau; most samples produce none.
// Registers are written through i_cfg_wr_en / i_cfg_addr / i_cfg_wdata and
// should change only while no request is in flight.
// Path: a peak found for a sample passes the input register, then the
// result register, on its way to m_axis. Throughput: one sample per cycle
// while m_axis does not stall, as the rule compare between the two
// registers is combinational. s_axis_tready drops only while both registers hold work and the
// result is not taken; a stalled result holds and samples keep flowing while
// the input register can still move on.
// Reset (synchronous, active low) restores register defaults, clears the
// window, counters and both valid flags.
module adc_pulse_peak_finder_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [adcppf_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // [12:0] adc_sample
    input  logic                                  s_axis_tuser,  // [0] pad_start
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [8:0] peak_bucket, [21:9] peak_height, [24:22] plateau_length,
    // [33:25] peak_ordinal
    output logic [adcppf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                  i_cfg_wr_en,
    input  logic [adcppf_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [adcppf_pkg::CFG_W-1:0]          i_cfg_wdata
);

    adcppf_pkg::t_cfg r_cfg;
    logic s_accept, a_valid, a_pad, a_fire, out_free, out_valid;
    adcppf_pkg::t_taps a_taps;
    logic [adcppf_pkg::BUCKET_W-1:0] a_bucket;
    adcppf_pkg::t_cls cls;
    logic [adcppf_pkg::OUT_BKT_W-1:0] peak_bucket;
    logic [adcppf_pkg::SAMPLE_W-1:0] peak_height;
    logic [adcppf_pkg::LEN_W-1:0] plateau_length;
    logic [adcppf_pkg::ORD_W-1:0] peak_ordinal;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.height_threshold    <= 12'd30;
            r_cfg.saturation_level    <= 12'd3500;
            r_cfg.first_active_bucket <= 9'd25;
            r_cfg.samples_per_pad     <= 10'd270;
            r_cfg.minimum_rise        <= 12'd30;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                adcppf_pkg::REG_HEIGHT_THR: r_cfg.height_threshold <= i_cfg_wdata;
                adcppf_pkg::REG_SAT_LEVEL:  r_cfg.saturation_level <= i_cfg_wdata;
                adcppf_pkg::REG_FIRST_BKT:
                    r_cfg.first_active_bucket <= i_cfg_wdata[8:0];
                adcppf_pkg::REG_SAMPLES:
                    r_cfg.samples_per_pad <= i_cfg_wdata[adcppf_pkg::BUCKET_W-1:0];
                adcppf_pkg::REG_MIN_RISE:   r_cfg.minimum_rise <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake between the two register stages
    assign out_free      = !out_valid || m_axis_tready;
    assign a_fire        = a_valid && out_free;
    assign s_axis_tready = !a_valid || out_free;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    adcppf_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (s_accept),
        .i_sample    (s_axis_tdata[adcppf_pkg::SAMPLE_W-1:0]),
        .i_pad_start (s_axis_tuser),
        .i_advance   (a_fire),
        .o_valid     (a_valid),
        .o_taps      (a_taps),
        .o_bucket    (a_bucket),
        .o_pad_start (a_pad)
    );

    adcppf_classify u_classify (
        .i_taps   (a_taps),
        .i_bucket (a_bucket),
        .i_cfg    (r_cfg),
        .o_cls    (cls)
    );

    adcppf_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (a_fire),
        .i_pad_start      (a_pad),
        .i_cls            (cls),
        .i_ready          (m_axis_tready),
        .o_valid          (out_valid),
        .o_peak_bucket    (peak_bucket),
        .o_peak_height    (peak_height),
        .o_plateau_length (plateau_length),
        .o_peak_ordinal   (peak_ordinal)
    );

    // Pack the result record
    assign m_axis_tvalid = out_valid;
    assign m_axis_tdata  = {6'd0, peak_ordinal, plateau_length, peak_height, peak_bucket};

endmodule

FILE: src/adcppf_window.sv
// Sample window, bucket counter and the input register of the peak finder.
module adcppf_window (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [adcppf_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                             i_pad_start,
    input  logic                             i_advance,
    output logic                             o_valid,
    output adcppf_pkg::t_taps                o_taps,
    output logic [adcppf_pkg::BUCKET_W-1:0]  o_bucket,
    output logic                             o_pad_start
);

    logic [adcppf_pkg::TAPS-2:0][adcppf_pkg::SAMPLE_W-1:0] r_win;
    logic [adcppf_pkg::BUCKET_W-1:0] r_bucket;
    logic [adcppf_pkg::TAPS-2:0][adcppf_pkg::SAMPLE_W-1:0] n_win_base;
    logic [adcppf_pkg::BUCKET_W-1:0] n_bucket_base;
    logic r_valid;
    adcppf_pkg::t_taps r_taps;
    logic [adcppf_pkg::BUCKET_W-1:0] r_b;
    logic r_pad;

    // Clear history on a new pad before the sample is used
    always_comb begin
        n_win_base    = i_pad_start ? '0 : r_win;
        n_bucket_base = i_pad_start ? '0 : r_bucket;
    end

    // Shift the window and count buckets on each request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= '0;
            r_bucket <= '0;
        end else if (i_accept) begin
            r_win    <= {n_win_base[adcppf_pkg::TAPS-3:0], i_sample};
            r_bucket <= (n_bucket_base < adcppf_pkg::BUCKET_MAX)
                        ? n_bucket_base + 1'b1 : n_bucket_base;
        end
    end

    // Hold the full tap set of the request for the classify stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_taps <= {n_win_base, i_sample};
            r_b    <= n_bucket_base;
            r_pad  <= i_pad_start;
        end
    end

    assign o_valid     = r_valid;
    assign o_taps      = r_taps;
    assign o_bucket    = r_b;
    assign o_pad_start = r_pad;

endmodule

FILE: src/adcppf_classify.sv
// Peak and plateau rule set applied to one ten-sample window.
module adcppf_classify (
    input  adcppf_pkg::t_taps                i_taps,
    input  logic [adcppf_pkg::BUCKET_W-1:0]  i_bucket,
    input  adcppf_pkg::t_cfg                 i_cfg,
    output adcppf_pkg::t_cls                 o_cls
);

    logic signed [adcppf_pkg::CMP_W-1:0] d [adcppf_pkg::TAPS];
    logic signed [adcppf_pkg::CMP_W-1:0] thr, sat, rise;
    logic [adcppf_pkg::BUCKET_W:0] bkt_end, bkt_lim;
    logic in_range, u_shape, u_rise, s1, s2, s3, s4, s5;
    logic [2:0] off;
    logic [adcppf_pkg::LEN_W-1:0] len;
    logic found;
    logic [adcppf_pkg::BUCKET_W-1:0] bkt_diff;

    // Widen all operands to one signed compare width
    always_comb begin
        for (int k = 0; k < adcppf_pkg::TAPS; k++) begin
            d[k] = adcppf_pkg::sx(i_taps[k]);
        end
        thr  = adcppf_pkg::zx(i_cfg.height_threshold);
        sat  = adcppf_pkg::zx(i_cfg.saturation_level);
        rise = adcppf_pkg::zx(i_cfg.minimum_rise);
    end

    // Test only between the first active bucket and the end margin
    always_comb begin
        bkt_lim = (i_cfg.samples_per_pad < adcppf_pkg::MAX_BUCKETS)
                  ? {1'b0, i_cfg.samples_per_pad} : {1'b0, adcppf_pkg::MAX_BUCKETS};
        bkt_end = {1'b0, i_bucket} + adcppf_pkg::END_MARGIN;
        in_range = (i_bucket > {1'b0, i_cfg.first_active_bucket}) && (bkt_end < bkt_lim);
    end

    // Unsaturated peak at the third tap
    assign u_shape = d[2] > thr && d[2] < sat && d[2] > d[1] && d[1] > d[0]
                   && d[2] > d[3] && d[3] > d[4] && d[4] > d[5]
                   && d[5] > adcppf_pkg::TOL_NEG && d[4] > 0 && d[1] > 0
                   && d[0] > adcppf_pkg::TOL_NEG;
    assign u_rise = (d[2] - d[5] > rise)
                  || (d[5] > d[6] && d[2] - d[6] > rise && d[5] > 0
                      && d[6] > adcppf_pkg::TOL_NEG)
                  || (d[5] > d[6] && d[6] > d[7] && d[2] - d[7] > rise
                      && d[6] > 0 && d[7] > adcppf_pkg::TOL_NEG);

    // Saturated plateaus, one to five buckets long
    assign s1 = d[2] > sat && d[3] < sat && d[1] < sat && d[2] > d[1] && d[1] > d[0]
              && d[3] > d[4] && d[4] > d[5] && d[5] > d[6] && d[6] > d[7]
              && d[7] > 0 && d[0] > 0 && d[0] < sat && d[3] - d[7] > rise;
    assign s2 = d[3] > sat && d[2] > sat && d[4] < sat && d[1] < sat
              && d[2] > d[1] && d[1] > d[0] && d[4] > d[5] && d[5] > d[6]
              && d[7] > 0 && d[0] > 0 && d[0] < sat && d[4] - d[7] > rise;
    assign s3 = d[4] > sat && d[3] > sat && d[2] > sat && d[5] < sat && d[1] < sat
              && d[2] > d[1] && d[1] > d[0] && d[5] > d[6] && d[6] > d[7]
              && d[7] > 0 && d[0] > 0 && d[5] - d[7] > rise;
    assign s4 = d[5] > sat && d[4] > sat && d[3] > sat && d[2] > sat
              && d[6] < sat && d[1] < sat && d[2] > d[1] && d[1] > d[0]
              && d[6] > d[7] && d[7] > d[8] && d[8] > 0 && d[0] > 0
              && d[6] - d[8] > rise;
    assign s5 = d[6] > sat && d[5] > sat && d[4] > sat && d[3] > sat && d[2] > sat
              && d[7] < sat && d[1] < sat && d[2] > d[1] && d[1] > d[0]
              && d[7] > d[8] && d[8] > d[9] && d[9] > 0 && d[0] > 0
              && d[7] - d[9] > rise;

    // Pick the first matching rule; the unsaturated shape blocks the rest
    always_comb begin
        found = 1'b1;
        off   = 3'd2;
        len   = 3'd0;
        priority if (u_shape) begin
            found = u_rise;
        end else if (s1) begin
            off = 3'd3; len = 3'd1;
        end else if (s2) begin
            off = 3'd3; len = 3'd2;
        end else if (s3) begin
            off = 3'd4; len = 3'd3;
        end else if (s4) begin
            off = 3'd5; len = 3'd4;
        end else if (s5) begin
            off = 3'd6; len = 3'd5;
        end else begin
            found = 1'b0;
        end
    end

    // Report bucket and height of the selected tap
    always_comb begin
        bkt_diff = i_bucket - {7'd0, off};
        o_cls.hit            = in_range && found;
        o_cls.plateau_length = len;
        o_cls.peak_bucket    = bkt_diff[adcppf_pkg::OUT_BKT_W-1:0];
        o_cls.peak_height    = i_taps[{1'b0, off}];
    end

endmodule

FILE: src/adcppf_out.sv
// Peak ordinal counter and the result register of the peak finder.
module adcppf_out (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_fire,
    input  logic                             i_pad_start,
    input  adcppf_pkg::t_cls                 i_cls,
    input  logic                             i_ready,
    output logic                             o_valid,
    output logic [adcppf_pkg::OUT_BKT_W-1:0] o_peak_bucket,
    output logic [adcppf_pkg::SAMPLE_W-1:0]  o_peak_height,
    output logic [adcppf_pkg::LEN_W-1:0]     o_plateau_length,
    output logic [adcppf_pkg::ORD_W-1:0]     o_peak_ordinal
);

    logic [adcppf_pkg::ORD_W-1:0] r_cnt;
    logic [adcppf_pkg::ORD_W-1:0] n_cnt_base;
    logic r_valid;
    adcppf_pkg::t_cls r_cls;
    logic [adcppf_pkg::ORD_W-1:0] r_ord;

    assign n_cnt_base = i_pad_start ? '0 : r_cnt;

    // Count peaks per pad, saturating at the top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_fire) begin
            if (i_cls.hit && n_cnt_base < adcppf_pkg::ORD_MAX) begin
                r_cnt <= n_cnt_base + 1'b1;
            end else begin
                r_cnt <= n_cnt_base;
            end
        end
    end

    // Load a result, or drop the flag once it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire && i_cls.hit) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_cls.hit) begin
            r_cls <= i_cls;
            r_ord <= n_cnt_base;
        end
    end

    assign o_valid          = r_valid;
    assign o_peak_bucket    = r_cls.peak_bucket;
    assign o_peak_height    = r_cls.peak_height;
    assign o_plateau_length = r_cls.plateau_length;
    assign o_peak_ordinal   = r_ord;

    // A new pad restarts ordinals at zero
    a_pad_ord_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_pad_start && i_cls.hit) |=> (r_ord == '0))
        else $error("first peak of a pad has nonzero ordinal");

    // Within a pad the counter never goes back
    a_cnt_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_fire && i_pad_start) |=> (r_cnt >= $past(r_cnt)))
        else $error("peak counter decreased inside a pad");

    // Every hit reaches the result register
    a_hit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_cls.hit) |=> r_valid)
        else $error("peak lost on the way to the result register");

    // A hit only moves while the result register is free or being drained
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_cls.hit) |-> (!r_valid || i_ready))
        else $error("pending result overwritten");

endmodule
